FILE: rtl/tid_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tid_pkg: shared types and codes of the table id lookup block
// Opcodes, register indexes, field widths and the structs passed between the
// top level and the search sequencer.
// ============================================================================
package tid_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W = 32;
    localparam int IDX_W = 10;
    localparam int CFG_W = 11;
    localparam int POS_W = 11;

    // Item opcodes
    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SORTED_LIMIT = 1'b0,
        REG_ENTRY_COUNT  = 1'b1
    } reg_index_t;

    // Effective search bounds after clamping
    typedef struct packed {
        logic [POS_W-1:0] limit;
        logic [POS_W-1:0] count;
    } cfg_t;

    // Finished lookup offered to the output stage
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] index;
    } res_t;

endpackage

FILE: rtl/tid_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// tid_mem: id table storage
// Single-clock memory with one write port and one read port; read data is
// registered, so it appears in the cycle after the address.
// ============================================================================
module tid_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [tid_pkg::KEY_W-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [tid_pkg::KEY_W-1:0] rd_data
);
    import tid_pkg::*;

    logic [KEY_W-1:0] id_table_reg [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Write and read the table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_table_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= id_table_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/tid_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// tid_ctrl: request sequencer of the id lookup
// Takes write requests straight into the table and walks lookups through the
// direct probe, the binary search and the tail scan, one table read a cycle.
// ============================================================================
module tid_ctrl #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic [tid_pkg::IDX_W-1:0] entry_index,
    input  logic [tid_pkg::KEY_W-1:0] key_id,
    input  tid_pkg::cfg_t             cfg,
    output tid_pkg::res_t             res,
    input  logic                      res_take,
    output logic                      mem_wr_en,
    output logic [AW-1:0]             mem_wr_addr,
    output logic [tid_pkg::KEY_W-1:0] mem_wr_data,
    output logic                      mem_rd_en,
    output logic [AW-1:0]             mem_rd_addr,
    input  logic [tid_pkg::KEY_W-1:0] mem_rd_data
);
    import tid_pkg::*;

    localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PROBE = 5'b00010,
        ST_BIN   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [POS_W-1:0] low_reg, low_next;
    logic [POS_W-1:0] high_reg, high_next;
    logic [POS_W-1:0] cur_reg, cur_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pos_reg, pos_next;

    logic             bin_req;
    logic [POS_W-1:0] bin_l, bin_h, mid;
    logic             scan_req;
    logic [POS_W-1:0] scan_c;
    logic             fin, fin_found;
    logic [POS_W-1:0] fin_pos;
    logic [POS_W-1:0] rd_pos;

    // Accept new requests only between lookups
    assign in_ready = (state_reg == ST_IDLE);

    // Write requests go straight to the table; out-of-range positions drop
    assign mem_wr_en   = in_valid && in_ready && (opcode == OP_WRITE)
                         && (17'(entry_index) < DEPTH_V);
    assign mem_wr_addr = AW'(entry_index);
    assign mem_wr_data = key_id;

    assign mem_rd_addr = AW'(rd_pos);

    // Step the lookup: decide on the current read data and issue the next read
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        cur_next   = cur_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        mem_rd_en  = 1'b0;
        rd_pos     = '0;
        bin_req    = 1'b0;
        bin_l      = low_reg;
        bin_h      = high_reg;
        mid        = '0;
        scan_req   = 1'b0;
        scan_c     = cur_reg;
        fin        = 1'b0;
        fin_found  = 1'b0;
        fin_pos    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (opcode == OP_LOOKUP))
                begin
                    key_next = key_id;
                    if (key_id == '0)
                    begin
                        fin = 1'b1;
                    end
                    else if (key_id < KEY_W'(cfg.limit))
                    begin
                        mem_rd_en  = 1'b1;
                        rd_pos     = key_id[POS_W-1:0];
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        bin_req = 1'b1;
                        bin_l   = '0;
                        bin_h   = cfg.limit;
                    end
                end
            end
            ST_PROBE:
            begin
                if (mem_rd_data == key_reg)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_pos   = key_reg[POS_W-1:0];
                end
                else
                begin
                    bin_req = 1'b1;
                    bin_l   = '0;
                    bin_h   = cfg.limit;
                end
            end
            ST_BIN:
            begin
                if (mem_rd_data == key_reg)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_pos   = cur_reg;
                end
                else if (mem_rd_data < key_reg)
                begin
                    bin_req = 1'b1;
                    bin_l   = cur_reg + POS_W'(1);
                    bin_h   = high_reg;
                end
                else
                begin
                    bin_req = 1'b1;
                    bin_l   = low_reg;
                    bin_h   = cur_reg;
                end
            end
            ST_SCAN:
            begin
                if (mem_rd_data == '0)
                begin
                    fin = 1'b1;
                end
                else if (mem_rd_data == key_reg)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_pos   = cur_reg;
                end
                else
                begin
                    scan_req = 1'b1;
                    scan_c   = cur_reg + POS_W'(1);
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Next binary step, or fall into the tail scan once the range is empty
        if (bin_req)
        begin
            low_next  = bin_l;
            high_next = bin_h;
            if (bin_l == bin_h)
            begin
                scan_req = 1'b1;
                scan_c   = cfg.limit;
            end
            else
            begin
                mid        = bin_l + ((bin_h - bin_l) >> 1);
                cur_next   = mid;
                mem_rd_en  = 1'b1;
                rd_pos     = mid;
                state_next = ST_BIN;
            end
        end

        // Next scan entry, or finish as not found at the end of the table
        if (scan_req)
        begin
            if (scan_c >= cfg.count)
            begin
                fin = 1'b1;
            end
            else
            begin
                cur_next   = scan_c;
                mem_rd_en  = 1'b1;
                rd_pos     = scan_c;
                state_next = ST_SCAN;
            end
        end

        // Hold the answer until the output stage takes it
        if (fin)
        begin
            state_next = ST_DONE;
            found_next = fin_found;
            pos_next   = fin_found ? fin_pos[IDX_W-1:0] : '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search registers
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        low_reg   <= low_next;
        high_reg  <= high_next;
        cur_reg   <= cur_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    assign res.valid = (state_reg == ST_DONE);
    assign res.found = found_reg;
    assign res.index = pos_reg;

endmodule

FILE: rtl/table_id_lookup.sv
`timescale 1ns / 1ps
// ============================================================================
// table_id_lookup: table of 32-bit ids with lookup by id
// Write requests store an id at a table position; lookup requests return
// whether and where a key id is held, via direct probe, binary search and
// tail scan.
// ============================================================================
// A write request gives no result. A lookup request, once accepted, first
// runs the direct probe when the key is below the sorted limit, then the
// binary steps (at most ceil(log2(limit+1))), then the tail scan over the
// entries from the sorted limit on, as needed, before its result is
// loaded into the output register; a zero key reads no entry. Each
// of these steps is one read of the single read port of the id memory,
// whose registered data decides the address of the next read. The next
// request is taken while a result still waits in the output register. The
// id memory has no reset: positions below entry_count must be written before
// a lookup reaches them. entry_count above TABLE_DEPTH is treated as
// TABLE_DEPTH, and the sorted limit is clamped to the count.
module table_id_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      opcode,
    input  logic [tid_pkg::IDX_W-1:0] entry_index,
    input  logic [tid_pkg::KEY_W-1:0] key_id,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic [tid_pkg::IDX_W-1:0] found_index,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tid_pkg::CFG_W-1:0] cfg_data
);
    import tid_pkg::*;

    localparam int          AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_V = 17'(TABLE_DEPTH);

    logic [CFG_W-1:0] sorted_limit_reg;
    logic [CFG_W-1:0] entry_count_reg;
    logic [POS_W-1:0] count_eff;
    cfg_t             cfg;
    res_t             res;
    logic             res_take;

    logic             out_valid_reg, out_valid_next;
    logic             found_reg;
    logic [IDX_W-1:0] found_index_reg;

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [KEY_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [KEY_W-1:0] mem_rd_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_limit_reg <= '0;
            entry_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SORTED_LIMIT: sorted_limit_reg <= cfg_data;
                REG_ENTRY_COUNT:  entry_count_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp count to the table depth and the limit to the count
    assign count_eff = (17'(entry_count_reg) > DEPTH_V) ? POS_W'(DEPTH_V)
                                                        : entry_count_reg;
    assign cfg.count = count_eff;
    assign cfg.limit = (sorted_limit_reg > count_eff) ? count_eff : sorted_limit_reg;

    tid_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .entry_index (entry_index),
        .key_id      (key_id),
        .cfg         (cfg),
        .res         (res),
        .res_take    (res_take),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tid_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Load a finished lookup when the output register is free or draining
    assign res_take = res.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            found_reg       <= res.found;
            found_index_reg <= res.index;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;

endmodule

FILE: rtl/tid_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tid_checker: port-level checks of the table id lookup
// Watches the request and result channels of the top level over time.
// ============================================================================
module tid_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      opcode,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      found,
    input logic [tid_pkg::IDX_W-1:0] found_index
);
    import tid_pkg::*;

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(found_index))
        else $error("result changed while stalled");

    // A miss always reports position zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> found_index == '0)
        else $error("miss with nonzero position");

    // A write request taken with no result pending produces none
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_WRITE) && !out_valid |=> !out_valid)
        else $error("write request produced a result");

    // A lookup occupies the block for at least the next cycle
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_LOOKUP) |=> !in_ready)
        else $error("request taken during a lookup");

endmodule

bind table_id_lookup tid_checker u_checker (.*);
